// ===== sv/peba_pkg.sv =====
package peba_pkg;

  // field widths fixed by the item formats
  localparam int IDX_W      = 17;
  localparam int WADDR_W    = 16;
  localparam int PIX_W      = 8;
  localparam int DIM_W      = 9;
  localparam int THR_W      = 8;
  localparam int TOTAL_W    = 2 * DIM_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  // restoring divider, one quotient bit per step
  localparam int DIV_STEPS = IDX_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  localparam logic [DIM_W-1:0] ROWS_RST   = 9'd256;
  localparam logic [DIM_W-1:0] COLS_RST   = 9'd256;
  localparam logic [THR_W-1:0] THRESH_RST = 8'd127;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROWS   = 2'd0,
    CFG_COLS   = 2'd1,
    CFG_THRESH = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIV_A,
    S_DIV_B,
    S_BASE,
    S_SCAN,
    S_DRAIN
  } state_e;

  // order in which the box sides are walked
  typedef enum logic [1:0] {
    L_TOP,
    L_RIGHT,
    L_LEFT,
    L_BOTTOM
  } line_e;

  typedef struct packed {
    logic               req_type;
    logic [WADDR_W-1:0] write_address;
    logic [PIX_W-1:0]   pixel_magnitude;
    logic [IDX_W-1:0]   first_index;
    logic [IDX_W-1:0]   second_index;
  } req_t;

  typedef struct packed {
    logic             full_affinity;
    logic [PIX_W-1:0] peak_magnitude;
    logic             index_error;
  } res_t;

endpackage

// ===== sv/peba_div.sv =====
module peba_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [peba_pkg::IDX_W-1:0]    dividend_i,
  input  logic [peba_pkg::DIM_W-1:0]    divisor_i,
  output logic                          done_o,
  output logic [peba_pkg::IDX_W-1:0]    quot_o,
  output logic [peba_pkg::DIM_W-1:0]    rem_o
);
  import peba_pkg::*;

  logic [DIM_W-1:0]     rem_q, rem_d;
  logic [DIM_W-1:0]     dvs_q, dvs_d;
  logic [IDX_W-1:0]     quot_q, quot_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 run_q, run_d;
  logic                 done_q, done_d;
  logic [DIM_W:0]       trial;
  logic                 fits;

  always_comb begin
    trial  = {rem_q, quot_q[IDX_W-1]};
    fits   = (trial >= {1'b0, dvs_q});
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quot_d = quot_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quot_d = dividend_i;
      dvs_d  = divisor_i;
      cnt_d  = DIV_CNT_W'(DIV_STEPS);
      run_d  = 1'b1;
    end else if (run_q) begin
      // shift in next dividend bit, subtract when it fits
      rem_d  = fits ? DIM_W'(trial - {1'b0, dvs_q}) : trial[DIM_W-1:0];
      quot_d = {quot_q[IDX_W-2:0], fits};
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == DIV_CNT_W'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

// ===== sv/peba_store.sv =====
module peba_store #(
  parameter int DEPTH    = 65536,
  parameter int ADDR_W   = 16,
  parameter int MAG_BITS = 8
) (
  input  logic                clk_i,
  input  logic                wr_en_i,
  input  logic [ADDR_W-1:0]   wr_addr_i,
  input  logic [MAG_BITS-1:0] wr_data_i,
  input  logic                rd_en_i,
  input  logic [ADDR_W-1:0]   rd_addr_i,
  output logic [MAG_BITS-1:0] rd_data_o
);

  // contents undefined until written
  logic [MAG_BITS-1:0] mem [DEPTH];
  logic [MAG_BITS-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== sv/pair_edge_barrier_affinity.sv =====
// Intervening-contour affinity over a column-major edge-magnitude image. A word with
// req_type 0 stores one magnitude at write_address (addresses past the store are dropped)
// and finishes in the cycle it is taken, giving no result. A word with req_type 1 asks
// for the affinity of two 1-based pixel indices and gives exactly one result word, shown
// on result_o for a single cycle with result_stb_o high; the receiver cannot stall it, so
// it must take every strobed word. A bad index (0 or above rows*cols) answers
// with index_error set, and two equal indices answer with full affinity and
// peak 0. Any other pair runs two 17-step divisions on one shared divider to get row and
// column of each pixel, then walks the four sides of the bounding box through the single
// read port of the magnitude store, one pixel per cycle. busy is high for the whole query,
// and the result word follows in the cycle after the last busy cycle. The rows and cols
// registers are clamped into 1..MAX_ROWS and 1..MAX_COLS. Configuration writes take effect
// at once and must only be made while busy is low. The store has no reset; reading a pixel
// never written gives an undefined peak.
module pair_edge_barrier_affinity #(
  parameter int MAX_ROWS = 256,
  parameter int MAX_COLS = 256,
  parameter int MAG_BITS = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  peba_pkg::req_t                      req_i,
  input  logic                                cfg_we_i,
  input  logic [peba_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [peba_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output logic                                result_stb_o,
  output peba_pkg::res_t                      result_o
);
  import peba_pkg::*;

  localparam int DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W = $clog2(DEPTH);

  // configuration registers
  logic [DIM_W-1:0] rows_cfg_q;
  logic [DIM_W-1:0] cols_cfg_q;
  logic [THR_W-1:0] thr_q;

  // clamped geometry
  logic [DIM_W-1:0]   rows;
  logic [DIM_W-1:0]   cols;
  logic [TOTAL_W-1:0] total;

  // sequencer state
  state_e            state_q, state_d;
  line_e             line_q, line_d;
  logic [IDX_W-1:0]  ia_q, ia_d, ib_q, ib_d;
  logic [DIM_W-1:0]  ra_q, ra_d, ca_q, ca_d;
  logic [DIM_W-1:0]  rlo_q, rlo_d, rhi_q, rhi_d, clo_q, clo_d, chi_q, chi_d;
  logic [DIM_W-1:0]  rsel_q, rsel_d;
  logic              sel_a_q, sel_a_d;
  logic [ADDR_W-1:0] base_q, base_d, ptr_q, ptr_d;
  logic [DIM_W-1:0]  cnt_q, cnt_d;
  logic              rd_vld_q, rd_vld_d;
  logic [MAG_BITS-1:0] peak_q, peak_d, peak_nx;
  res_t              res_q, res_d;
  logic              res_stb_q, res_stb_d;

  logic              accept;
  logic              bad_idx;
  logic [IDX_W-1:0]  base_sum;

  // divider hookup
  logic              div_start;
  logic [IDX_W-1:0]  div_dividend;
  logic              div_done;
  logic [IDX_W-1:0]  div_quot;
  logic [DIM_W-1:0]  div_rem;

  // store hookup
  logic                wr_en;
  logic                rd_en;
  logic [MAG_BITS-1:0] rd_data;

  // geometry clamp into the legal range
  always_comb begin
    rows = rows_cfg_q;
    if (rows_cfg_q == '0) begin
      rows = DIM_W'(1);
    end else if (32'(rows_cfg_q) > 32'(MAX_ROWS)) begin
      rows = DIM_W'(MAX_ROWS);
    end
    cols = cols_cfg_q;
    if (cols_cfg_q == '0) begin
      cols = DIM_W'(1);
    end else if (32'(cols_cfg_q) > 32'(MAX_COLS)) begin
      cols = DIM_W'(MAX_COLS);
    end
  end

  assign total   = TOTAL_W'(rows) * TOTAL_W'(cols);
  assign accept  = start && !busy;
  assign bad_idx = (ia_q == '0) || (ib_q == '0) ||
                   (TOTAL_W'(ia_q) > total) || (TOTAL_W'(ib_q) > total);

  // running max over the word coming back from the store
  assign peak_nx = (rd_vld_q && (rd_data > peak_q)) ? rd_data : peak_q;

  // corner address of the box: index of the pixel in the low column, moved to the low row
  assign base_sum = (sel_a_q ? (ia_q - 1'b1) : (ib_q - 1'b1)) - IDX_W'(rsel_q) + IDX_W'(rlo_q);

  assign wr_en = accept && (req_i.req_type == REQ_WRITE) &&
                 (32'(req_i.write_address) < 32'(DEPTH));

  // configuration write port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_cfg_q <= ROWS_RST;
      cols_cfg_q <= COLS_RST;
      thr_q      <= THRESH_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_ROWS:   rows_cfg_q <= cfg_data_i;
        CFG_COLS:   cols_cfg_q <= cfg_data_i;
        CFG_THRESH: thr_q      <= cfg_data_i[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer: check, two divisions, box setup, perimeter walk
  always_comb begin
    state_d      = state_q;
    line_d       = line_q;
    ia_d         = ia_q;
    ib_d         = ib_q;
    ra_d         = ra_q;
    ca_d         = ca_q;
    rlo_d        = rlo_q;
    rhi_d        = rhi_q;
    clo_d        = clo_q;
    chi_d        = chi_q;
    rsel_d       = rsel_q;
    sel_a_d      = sel_a_q;
    base_d       = base_q;
    ptr_d        = ptr_q;
    cnt_d        = cnt_q;
    peak_d       = peak_nx;
    res_d        = res_q;
    res_stb_d    = 1'b0;
    rd_vld_d     = 1'b0;
    rd_en        = 1'b0;
    div_start    = 1'b0;
    div_dividend = ia_q - 1'b1;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          ia_d = req_i.first_index;
          ib_d = req_i.second_index;
          if (req_i.req_type == REQ_QUERY) begin
            state_d = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (bad_idx) begin
          res_d     = '{full_affinity: 1'b0, peak_magnitude: '0, index_error: 1'b1};
          res_stb_d = 1'b1;
          state_d   = S_IDLE;
        end else if (ia_q == ib_q) begin
          res_d     = '{full_affinity: 1'b1, peak_magnitude: '0, index_error: 1'b0};
          res_stb_d = 1'b1;
          state_d   = S_IDLE;
        end else begin
          div_start = 1'b1;
          state_d   = S_DIV_A;
        end
      end
      S_DIV_A: begin
        div_dividend = ib_q - 1'b1;
        if (div_done) begin
          // quotient is below cols once the index passed the check
          ra_d      = div_rem;
          ca_d      = div_quot[DIM_W-1:0];
          div_start = 1'b1;
          state_d   = S_DIV_B;
        end
      end
      S_DIV_B: begin
        if (div_done) begin
          sel_a_d = (ca_q <= div_quot[DIM_W-1:0]);
          rsel_d  = (ca_q <= div_quot[DIM_W-1:0]) ? ra_q : div_rem;
          clo_d   = (ca_q <= div_quot[DIM_W-1:0]) ? ca_q : div_quot[DIM_W-1:0];
          chi_d   = (ca_q <= div_quot[DIM_W-1:0]) ? div_quot[DIM_W-1:0] : ca_q;
          rlo_d   = (ra_q <= div_rem) ? ra_q : div_rem;
          rhi_d   = (ra_q <= div_rem) ? div_rem : ra_q;
          state_d = S_BASE;
        end
      end
      S_BASE: begin
        base_d  = ADDR_W'(base_sum);
        ptr_d   = ADDR_W'(base_sum);
        cnt_d   = chi_q - clo_q;
        line_d  = L_TOP;
        peak_d  = '0;
        state_d = S_SCAN;
      end
      S_SCAN: begin
        rd_en    = 1'b1;
        rd_vld_d = 1'b1;
        if (cnt_q == '0) begin
          // each side starts where the previous ended or at the low corner
          unique case (line_q)
            L_TOP: begin
              line_d = L_RIGHT;
              cnt_d  = rhi_q - rlo_q;
            end
            L_RIGHT: begin
              line_d = L_LEFT;
              ptr_d  = base_q;
              cnt_d  = rhi_q - rlo_q;
            end
            L_LEFT: begin
              line_d = L_BOTTOM;
              cnt_d  = chi_q - clo_q;
            end
            L_BOTTOM: begin
              state_d = S_DRAIN;
            end
            default: ;
          endcase
        end else begin
          cnt_d = cnt_q - 1'b1;
          if ((line_q == L_TOP) || (line_q == L_BOTTOM)) begin
            ptr_d = ptr_q + ADDR_W'(rows);
          end else begin
            ptr_d = ptr_q + ADDR_W'(1);
          end
        end
      end
      S_DRAIN: begin
        // last read word lands here
        res_d.full_affinity  = !(32'(peak_nx) > 32'(thr_q));
        res_d.peak_magnitude = PIX_W'(peak_nx);
        res_d.index_error    = 1'b0;
        res_stb_d            = 1'b1;
        state_d              = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      line_q    <= L_TOP;
      cnt_q     <= '0;
      rd_vld_q  <= 1'b0;
      res_stb_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      line_q    <= line_d;
      cnt_q     <= cnt_d;
      rd_vld_q  <= rd_vld_d;
      res_stb_q <= res_stb_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ia_q    <= ia_d;
    ib_q    <= ib_d;
    ra_q    <= ra_d;
    ca_q    <= ca_d;
    rlo_q   <= rlo_d;
    rhi_q   <= rhi_d;
    clo_q   <= clo_d;
    chi_q   <= chi_d;
    rsel_q  <= rsel_d;
    sel_a_q <= sel_a_d;
    base_q  <= base_d;
    ptr_q   <= ptr_d;
    peak_q  <= peak_d;
    res_q   <= res_d;
  end

  peba_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (rows),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  peba_store #(
    .DEPTH    (DEPTH),
    .ADDR_W   (ADDR_W),
    .MAG_BITS (MAG_BITS)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (ADDR_W'(req_i.write_address)),
    .wr_data_i (MAG_BITS'(req_i.pixel_magnitude)),
    .rd_en_i   (rd_en),
    .rd_addr_i (ptr_q),
    .rd_data_o (rd_data)
  );

  assign busy         = (state_q != S_IDLE);
  assign result_stb_o = res_stb_q;
  assign result_o     = res_q;

  // a result word is never followed by another in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_stb_q |=> !res_stb_q)
    else $error("back-to-back result words");

  // an index error word carries no affinity and no peak
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_stb_q && res_q.index_error) |-> (!res_q.full_affinity && (res_q.peak_magnitude == '0)))
    else $error("index error word with payload");

  // a pixel write never occupies the sequencer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (req_i.req_type == REQ_WRITE)) |=> !busy)
    else $error("write left the block busy");

  // the divider only reports back while a division is awaited
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> ((state_q == S_DIV_A) || (state_q == S_DIV_B)))
    else $error("divider result outside division states");

  // store reads only happen during the perimeter walk
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> ((state_q == S_SCAN) || (state_q == S_DRAIN)))
    else $error("store read outside the walk");

endmodule

// ===== sim/tb_pair_edge_barrier_affinity.sv =====
module tb_pair_edge_barrier_affinity;
  import peba_pkg::*;

  // image size the block is built with (its parameter defaults)
  localparam int IMG_MAX      = 256;
  localparam int STORE_WORDS  = IMG_MAX * IMG_MAX;
  localparam int IDX_ALL      = (1 << IDX_W) - 1;
  // longest query: full 256 by 256 box walk
  localparam int DRAIN_CYCLES = 1100;
  localparam int PHASE_WORDS  = 24;

  // fixed geometries first: row vector, clamp from zero, clamp from above, reset values, both clamped from above
  localparam int FIXED_PHASES  = 5;
  localparam int RANDOM_PHASES = 5;
  localparam int FIX_ROWS [FIXED_PHASES] = '{1, 0, 511, 256, 300};
  localparam int FIX_COLS [FIXED_PHASES] = '{256, 0, 2, 256, 400};
  localparam int FIX_THR  [FIXED_PHASES] = '{0, 255, 200, 127, 90};
  // sender idle percentage, cycled per phase
  localparam int GAP_PCT [3] = '{0, 52, 28};

  logic                  clk_i      = 1'b0;
  logic                  rst_ni     = 1'b0;
  logic                  start      = 1'b0;
  logic                  busy;
  req_t                  req_i      = '0;
  logic                  cfg_we_i   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i  = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  result_stb_o;
  res_t                  result_o;

  // register copies as the block sees them
  logic [DIM_W-1:0] model_rows = ROWS_RST;
  logic [DIM_W-1:0] model_cols = COLS_RST;
  logic [THR_W-1:0] model_thr  = THRESH_RST;
  // magnitude image, updated when a write word is taken
  logic [PIX_W-1:0] mag_mirror [STORE_WORDS];

  req_t word_queue [$];
  res_t affinity_due [$];
  int   mismatch_cnt = 0;
  int   gap_pct      = 0;

  // generator side: pixels that some queued write will have filled,
  // so no query ever walks over an unwritten pixel
  bit plan_written [STORE_WORDS];
  int plan_rows = IMG_MAX;
  int plan_cols = IMG_MAX;
  int plan_thr  = int'(THRESH_RST);

  pair_edge_barrier_affinity u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .req_i        (req_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .result_stb_o (result_stb_o),
    .result_o     (result_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // geometry registers are saturated into 1..IMG_MAX before use
  function automatic int eff_dim(logic [DIM_W-1:0] v);
    if (v == '0) return 1;
    if (v > IMG_MAX) return IMG_MAX;
    return int'(v);
  endfunction

  // expected answer for one query word against the current image and registers
  function automatic res_t affinity_predict(req_t w);
    int   rows, cols, ia, ib, ra, ca, rb, cb, rlo, rhi, clo, chi, peak, a;
    res_t r;
    rows = eff_dim(model_rows);
    cols = eff_dim(model_cols);
    ia   = int'(w.first_index);
    ib   = int'(w.second_index);
    r    = '0;
    // bad index: zero or past the image, no pixel is read
    if (ia == 0 || ib == 0 || ia > rows * cols || ib > rows * cols) begin
      r.index_error = 1'b1;
      return r;
    end
    // same pixel: full affinity, peak zero
    if (ia == ib) begin
      r.full_affinity = 1'b1;
      return r;
    end
    ra   = (ia - 1) % rows;
    ca   = (ia - 1) / rows;
    rb   = (ib - 1) % rows;
    cb   = (ib - 1) / rows;
    rlo  = (ra < rb) ? ra : rb;
    rhi  = (ra < rb) ? rb : ra;
    clo  = (ca < cb) ? ca : cb;
    chi  = (ca < cb) ? cb : ca;
    peak = 0;
    // top and bottom sides
    for (int c = clo; c <= chi; c++) begin
      for (int s = 0; s < 2; s++) begin
        a = ((s == 0) ? rlo : rhi) + c * rows;
        if (int'(mag_mirror[a]) > peak) peak = int'(mag_mirror[a]);
      end
    end
    // left and right sides
    for (int rr = rlo; rr <= rhi; rr++) begin
      for (int s = 0; s < 2; s++) begin
        a = rr + ((s == 0) ? clo : chi) * rows;
        if (int'(mag_mirror[a]) > peak) peak = int'(mag_mirror[a]);
      end
    end
    r.full_affinity  = (peak > int'(model_thr)) ? 1'b0 : 1'b1;
    r.peak_magnitude = peak[PIX_W-1:0];
    return r;
  endfunction

  // driver: a word is taken at an edge with start high and busy low;
  // start stays up until then, the next word may follow back to back
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
      req_i <= '0;
    end else begin
      if (start && !busy) begin
        if (req_i.req_type == REQ_WRITE) begin
          mag_mirror[req_i.write_address] = req_i.pixel_magnitude;
        end else begin
          affinity_due.push_back(affinity_predict(req_i));
        end
      end
      // free to present a new word when nothing is held or the held one was taken
      if (!start || !busy) begin
        if (word_queue.size() != 0 && $urandom_range(99) >= gap_pct) begin
          start <= 1'b1;
          req_i <= word_queue.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: every strobed result word is matched against the oldest expectation
  always @(posedge clk_i) begin : result_watch
    res_t due;
    if (rst_ni && result_stb_o) begin
      if (affinity_due.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("result word with nothing pending: aff=%0b peak=%0d err=%0b",
                   result_o.full_affinity, result_o.peak_magnitude, result_o.index_error);
      end else begin
        due = affinity_due.pop_front();
        if (result_o.full_affinity !== due.full_affinity ||
            result_o.peak_magnitude !== due.peak_magnitude ||
            result_o.index_error !== due.index_error) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch: expected aff=%0b peak=%0d err=%0b, got aff=%0b peak=%0d err=%0b",
                     due.full_affinity, due.peak_magnitude, due.index_error,
                     result_o.full_affinity, result_o.peak_magnitude, result_o.index_error);
        end
      end
    end
  end

  // unused index fields carry random bits
  task automatic push_write(int a, int m);
    req_t w;
    w.req_type        = REQ_WRITE;
    w.write_address   = a[WADDR_W-1:0];
    w.pixel_magnitude = m[PIX_W-1:0];
    w.first_index     = IDX_W'($urandom_range(IDX_ALL));
    w.second_index    = IDX_W'($urandom_range(IDX_ALL));
    plan_written[a[WADDR_W-1:0]] = 1'b1;
    word_queue.push_back(w);
  endtask

  // unused write fields carry random bits
  task automatic push_query(int ia, int ib);
    req_t w;
    w.req_type        = REQ_QUERY;
    w.write_address   = WADDR_W'($urandom_range(STORE_WORDS - 1));
    w.pixel_magnitude = PIX_W'($urandom_range(255));
    w.first_index     = ia[IDX_W-1:0];
    w.second_index    = ib[IDX_W-1:0];
    word_queue.push_back(w);
  endtask

  // well-formed query: fill the box outline first, then ask for the pair
  task automatic add_box_query(int r0, int c0, int r1, int c1);
    int rlo, rhi, clo, chi, a;
    bit tame;
    rlo = (r0 < r1) ? r0 : r1;
    rhi = (r0 < r1) ? r1 : r0;
    clo = (c0 < c1) ? c0 : c1;
    chi = (c0 < c1) ? c1 : c0;
    // small boxes are sometimes rewritten at or below threshold so full affinity shows up
    tame = ((rhi - rlo) + (chi - clo) <= 32) && ($urandom_range(1) == 1);
    for (int c = clo; c <= chi; c++) begin
      for (int r = rlo; r <= rhi; r++) begin
        if (r == rlo || r == rhi || c == clo || c == chi) begin
          a = r + c * plan_rows;
          if (tame) begin
            push_write(a, $urandom_range(plan_thr, 0));
          end else if (!plan_written[a]) begin
            push_write(a, ($urandom_range(3) == 0) ? plan_thr : $urandom_range(255));
          end
        end
      end
    end
    // one bottom pixel just over the threshold
    if (tame && plan_thr < 255 && $urandom_range(1) == 1)
      push_write(rhi + $urandom_range(chi, clo) * plan_rows, plan_thr + 1);
    push_query(r0 + c0 * plan_rows + 1, r1 + c1 * plan_rows + 1);
  endtask

  function automatic int pick_near(int v, int span, int n);
    int lo, hi;
    lo = (v - span < 0) ? 0 : v - span;
    hi = (v + span > n - 1) ? n - 1 : v + span;
    return $urandom_range(hi, lo);
  endfunction

  // mostly well-formed boxes with random content, some noise
  task automatic add_random_words(int budget);
    int base, pick, r0, c0, r1, c1, span, total, bad, other;
    base  = word_queue.size();
    total = plan_rows * plan_cols;
    while (word_queue.size() - base < budget) begin
      pick = $urandom_range(99);
      r0   = $urandom_range(plan_rows - 1);
      c0   = $urandom_range(plan_cols - 1);
      if (pick < 8) begin
        // stray write anywhere in the store
        push_write($urandom_range(STORE_WORDS - 1), $urandom_range(255));
      end else if (pick < 18) begin
        // out-of-range index on one side or both
        case ($urandom_range(3))
          0:       bad = 0;
          1:       bad = total + 1;
          2:       bad = $urandom_range(IDX_ALL, total + 1);
          default: bad = IDX_ALL;
        endcase
        other = ($urandom_range(1) == 1) ? r0 + c0 * plan_rows + 1 : $urandom_range(IDX_ALL);
        if ($urandom_range(1) == 1) push_query(bad, other);
        else push_query(other, bad);
      end else if (pick < 26) begin
        push_query(r0 + c0 * plan_rows + 1, r0 + c0 * plan_rows + 1);
      end else begin
        // small images sometimes get boxes of any size
        span = (plan_rows <= 32 && plan_cols <= 32 && $urandom_range(7) == 0) ? IMG_MAX : 6;
        r1   = pick_near(r0, span, plan_rows);
        c1   = pick_near(c0, span, plan_cols);
        add_box_query(r0, c0, r1, c1);
      end
    end
  endtask

  // all words taken, all results back, block idle; writes finish in the cycle
  // they are taken so a short settle is enough
  task automatic wait_idle();
    @(negedge clk_i);
    while (word_queue.size() != 0 || start || busy || affinity_due.size() != 0)
      @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  // one register per cycle, model copies follow at once since the block is idle
  task automatic program_regs(int rows_v, int cols_v, int thr_v);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_ROWS;
    cfg_data_i <= rows_v[CFG_DATA_W-1:0];
    model_rows = rows_v[DIM_W-1:0];
    @(posedge clk_i);
    cfg_idx_i  <= CFG_COLS;
    cfg_data_i <= cols_v[CFG_DATA_W-1:0];
    model_cols = cols_v[DIM_W-1:0];
    @(posedge clk_i);
    cfg_idx_i  <= CFG_THRESH;
    cfg_data_i <= thr_v[CFG_DATA_W-1:0];
    model_thr  = thr_v[THR_W-1:0];
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    plan_rows = eff_dim(model_rows);
    plan_cols = eff_dim(model_cols);
    plan_thr  = int'(model_thr);
    @(negedge clk_i);
  endtask

  initial begin : stimulus
    int rows_v, cols_v, thr_v;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed part on reset geometry 256 by 256, threshold 127
    gap_pct = GAP_PCT[2];
    push_write(0, 127);
    push_write(1, 128);
    push_write(256, 127);
    push_write(257, 0);
    push_write(STORE_WORDS - 2, 255);
    push_write(STORE_WORDS - 1, 0);
    push_query(1, 2);                            // one pixel just over threshold
    push_query(2, 1);
    push_query(1, 257);                          // peak equal to threshold
    push_query(1, 258);
    push_query(STORE_WORDS, STORE_WORDS - 1);    // last pixel of the image
    push_query(STORE_WORDS - 1, STORE_WORDS);
    push_query(STORE_WORDS, STORE_WORDS);        // same pixel
    push_query(0, 5);                            // zero index
    push_query(5, 0);
    push_query(0, 0);
    push_query(STORE_WORDS + 1, 1);              // just past the image
    push_query(1, IDX_ALL);
    push_query(IDX_ALL, IDX_ALL);

    for (int p = 0; p < FIXED_PHASES + RANDOM_PHASES; p++) begin
      wait_idle();
      if (p < FIXED_PHASES) begin
        rows_v = FIX_ROWS[p];
        cols_v = FIX_COLS[p];
        thr_v  = FIX_THR[p];
      end else begin
        rows_v = $urandom_range(16, 2);
        cols_v = $urandom_range(16, 2);
        thr_v  = $urandom_range(255);
      end
      program_regs(rows_v, cols_v, thr_v);
      gap_pct = GAP_PCT[p % 3];
      // widest box: a whole image row of 256 pixels
      if (p == 0) begin
        add_box_query(0, 0, 0, IMG_MAX - 1);
        add_box_query(0, IMG_MAX - 1, 0, 0);
      end
      // tallest box: a whole column, same pixels as the row above
      if (p == 3) begin
        add_box_query(0, 0, IMG_MAX - 1, 0);
        add_box_query(IMG_MAX - 1, 0, 0, 0);
      end
      add_random_words(PHASE_WORDS);
    end

    wait_idle();
    // anything strobed late still gets caught by the monitor
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0 && affinity_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #50_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
